@@ rtl/ps2s1_pkg.sv @@
`timescale 1ns / 1ps

package ps2s1_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_key;

    typedef enum logic [1:0] {
        OP_FEED  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    localparam int unsigned NUM_KEYS  = 103;
    localparam t_key        KEY_PRINT = 7'd102;

    localparam t_byte SC_E0        = 8'hE0;
    localparam t_byte SC_E1        = 8'hE1;
    localparam t_byte SC_E0_HOLD_A = 8'hB7;
    localparam t_byte SC_E0_HOLD_B = 8'h2A;
    localparam t_byte SC_EXT_BREAK = 8'h90;
    localparam t_byte SC_PRT_MAKE  = 8'h37;
    localparam t_byte SC_PRT_BREAK = 8'hAA;
    localparam t_key  CODE_LIMIT   = 7'd89;

    localparam logic [2:0] SEQ_EXT_LEN   = 3'd2;
    localparam logic [2:0] SEQ_PRT_LEN   = 3'd4;
    localparam logic [2:0] SEQ_PAUSE_LEN = 3'd6;

    typedef struct packed {
        logic have;
        t_key key;
        logic pressed;
    } t_dec;

    // E0-prefixed code to key index; unmapped codes give key 0
    function automatic t_key ext_index(input t_key code);
        t_key k;
        case (code)
            7'h4B:   k = 7'd90;
            7'h48:   k = 7'd91;
            7'h4D:   k = 7'd92;
            7'h50:   k = 7'd93;
            7'h38:   k = 7'd88;
            7'h1D:   k = 7'd89;
            7'h47:   k = 7'd94;
            7'h49:   k = 7'd95;
            7'h4F:   k = 7'd96;
            7'h51:   k = 7'd97;
            7'h52:   k = 7'd98;
            7'h53:   k = 7'd99;
            7'h1C:   k = 7'd100;
            7'h35:   k = 7'd101;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/ps2s1_if.sv @@
`timescale 1ns / 1ps

interface ps2s1_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] scan_byte;
    logic [6:0] query_key;

    modport source (output valid, output op, output scan_byte, output query_key, input ready);
    modport sink   (input valid, input op, input scan_byte, input query_key, output ready);
endinterface

interface ps2s1_out_if;
    logic       valid;
    logic       ready;
    logic       event_valid;
    logic [6:0] event_key;
    logic       key_pressed;
    logic       event_dropped;

    modport source (output valid, output event_valid, output event_key, output key_pressed,
                    output event_dropped, input ready);
    modport sink   (input valid, input event_valid, input event_key, input key_pressed,
                    input event_dropped, output ready);
endinterface

@@ rtl/ps2_set1_scancode_decoder.sv @@
`timescale 1ns / 1ps

// PS/2 scancode set 1 decoder with key-state table and event ring.
// Input channel i_in carries op (feed byte, pop event, query key), scan_byte
// and query_key; every accepted item gives exactly one result item on o_out
// (event_valid, event_key, key_pressed, event_dropped).
// The accepting edge does the synchronous reads of the event ring and
// key-state memories alongside the lookup stage; the output register is
// loaded from the lookup stage when o_out is not stalled, and the result
// item is presented from the output register.
// Throughput: one item per cycle while o_out takes results; the
// single-port-per-side ring and key memories each take one access per item.
// Up to two items can be in flight: when o_out stalls, the block takes one
// more item into its lookup stage, then drops i_in.ready until the output
// register is taken.
// Reset clears the prefix-sequence state, the ring pointers and the valid bits
// of the key-state table (all keys read as released); there is no clearing
// pass, so items are accepted right after reset. Ring contents are undefined
// until written; data read from an empty ring is never used.
module ps2_set1_scancode_decoder #(
    parameter int unsigned EVENT_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2s1_in_if.sink             i_in,
    ps2s1_out_if.source          o_out
);

    logic              in_acc;
    logic              feed_acc;
    logic              pop_acc;
    logic              query_acc;
    logic              s1_move;
    ps2s1_pkg::t_dec   dec;
    logic              ring_full;
    logic              ring_empty;
    ps2s1_pkg::t_byte  ring_rd_data;
    logic              key_rd_pressed;
    logic              out_valid;

    logic              r_s1_valid;
    logic [1:0]        r_s1_op;
    ps2s1_pkg::t_dec   r_s1_dec;
    logic              r_s1_dropped;
    logic              r_s1_pop_ok;

    assign s1_move    = r_s1_valid && (!out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in.valid && i_in.ready;
    assign feed_acc   = in_acc && (i_in.op == ps2s1_pkg::OP_FEED);
    assign pop_acc    = in_acc && (i_in.op == ps2s1_pkg::OP_POP);
    assign query_acc  = in_acc && (i_in.op == ps2s1_pkg::OP_QUERY);

    ps2s1_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (feed_acc),
        .i_scan_byte (i_in.scan_byte),
        .o_dec       (dec)
    );

    ps2s1_ring #(
        .DEPTH (EVENT_DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (feed_acc && dec.have),
        .i_push_data ({dec.pressed, dec.key}),
        .i_pop       (pop_acc),
        .o_full      (ring_full),
        .o_empty     (ring_empty),
        .o_rd_data   (ring_rd_data)
    );

    ps2s1_keys u_keys (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (feed_acc && dec.have),
        .i_wr_key     (dec.key),
        .i_wr_pressed (dec.pressed),
        .i_rd_en      (query_acc),
        .i_rd_key     (i_in.query_key),
        .o_rd_pressed (key_rd_pressed)
    );

    // lookup stage: hold the item while memory read data lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op          <= i_in.op;
            r_s1_dropped     <= ring_full;
            r_s1_pop_ok      <= !ring_empty;
            r_s1_dec.have    <= dec.have;
            r_s1_dec.pressed <= dec.pressed;
            r_s1_dec.key     <= (i_in.op == ps2s1_pkg::OP_QUERY) ? i_in.query_key : dec.key;
        end
    end

    ps2s1_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_move),
        .i_op            (r_s1_op),
        .i_dec           (r_s1_dec),
        .i_dropped       (r_s1_dropped),
        .i_pop_ok        (r_s1_pop_ok),
        .i_ring_data     (ring_rd_data),
        .i_key_pressed   (key_rd_pressed),
        .i_take          (o_out.ready),
        .o_valid         (out_valid),
        .o_event_valid   (o_out.event_valid),
        .o_event_key     (o_out.event_key),
        .o_key_pressed   (o_out.key_pressed),
        .o_event_dropped (o_out.event_dropped)
    );

    assign o_out.valid = out_valid;

endmodule

@@ rtl/ps2s1_dec.sv @@
`timescale 1ns / 1ps

module ps2s1_dec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_feed,
    input  ps2s1_pkg::t_byte    i_scan_byte,
    output ps2s1_pkg::t_dec     o_dec
);

    logic [2:0] r_seq_count, n_seq_count;
    logic       r_seq_e0, n_seq_e0;
    logic [2:0] seq_inc;
    ps2s1_pkg::t_byte b;

    assign b       = i_scan_byte;
    assign seq_inc = r_seq_count + 3'd1;

    always_comb begin
        n_seq_count = r_seq_count;
        n_seq_e0    = r_seq_e0;
        o_dec       = '0;
        if (r_seq_count != 3'd0) begin
            n_seq_count = seq_inc;
            if (seq_inc == ps2s1_pkg::SEQ_EXT_LEN && r_seq_e0) begin
                // fake-shift bytes keep the sequence open
                if (b != ps2s1_pkg::SC_E0_HOLD_A && b != ps2s1_pkg::SC_E0_HOLD_B) begin
                    o_dec.have    = 1'b1;
                    o_dec.key     = ps2s1_pkg::ext_index(b[6:0]);
                    o_dec.pressed = (b < ps2s1_pkg::SC_EXT_BREAK);
                    n_seq_count   = 3'd0;
                end
            end else if (seq_inc == ps2s1_pkg::SEQ_PRT_LEN) begin
                if (b == ps2s1_pkg::SC_PRT_MAKE || b == ps2s1_pkg::SC_PRT_BREAK) begin
                    o_dec.have    = 1'b1;
                    o_dec.key     = ps2s1_pkg::KEY_PRINT;
                    o_dec.pressed = (b == ps2s1_pkg::SC_PRT_MAKE);
                    n_seq_count   = 3'd0;
                end
            end else if (seq_inc >= ps2s1_pkg::SEQ_PAUSE_LEN) begin
                // swallow the pause sequence
                n_seq_count = 3'd0;
            end
        end else if (b == ps2s1_pkg::SC_E0 || b == ps2s1_pkg::SC_E1) begin
            n_seq_e0    = (b == ps2s1_pkg::SC_E0);
            n_seq_count = 3'd1;
        end else if (b[6:0] != 7'd0 && b[6:0] < ps2s1_pkg::CODE_LIMIT) begin
            o_dec.have    = 1'b1;
            o_dec.key     = b[6:0] - 7'd1;
            o_dec.pressed = ~b[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count <= 3'd0;
            r_seq_e0    <= 1'b0;
        end else if (i_feed) begin
            r_seq_count <= n_seq_count;
            r_seq_e0    <= n_seq_e0;
        end
    end

endmodule

@@ rtl/ps2s1_keys.sv @@
`timescale 1ns / 1ps

module ps2s1_keys (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  ps2s1_pkg::t_key   i_wr_key,
    input  logic              i_wr_pressed,
    input  logic              i_rd_en,
    input  ps2s1_pkg::t_key   i_rd_key,
    output logic              o_rd_pressed
);

    logic                              mem [ps2s1_pkg::NUM_KEYS];
    logic [ps2s1_pkg::NUM_KEYS-1:0]    r_valid;
    logic                              r_rd_mem;
    logic                              r_rd_hit;
    logic                              wr_in_range;
    logic                              rd_in_range;

    assign wr_in_range = (32'(i_wr_key) < ps2s1_pkg::NUM_KEYS);
    assign rd_in_range = (32'(i_rd_key) < ps2s1_pkg::NUM_KEYS);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            mem[i_wr_key] <= i_wr_pressed;
        end
        if (i_rd_en) begin
            r_rd_mem <= rd_in_range ? mem[i_rd_key] : 1'b0;
        end
    end

    // an entry never written reads as released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && wr_in_range) begin
                r_valid[i_wr_key] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= rd_in_range && r_valid[i_rd_key];
            end
        end
    end

    assign o_rd_pressed = r_rd_hit & r_rd_mem;

endmodule

@@ rtl/ps2s1_ring.sv @@
`timescale 1ns / 1ps

module ps2s1_ring #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ps2s1_pkg::t_byte    i_push_data,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ps2s1_pkg::t_byte    o_rd_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    ps2s1_pkg::t_byte  mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_pos;
    logic [PTR_W-1:0]  r_rd_pos;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  rd_next;
    ps2s1_pkg::t_byte  r_rd_data;

    assign wr_next = (r_wr_pos == LAST) ? '0 : r_wr_pos + PTR_W'(1);
    assign rd_next = (r_rd_pos == LAST) ? '0 : r_rd_pos + PTR_W'(1);
    assign o_full  = (wr_next == r_rd_pos);
    assign o_empty = (r_wr_pos == r_rd_pos);

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            mem[r_wr_pos] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= mem[r_rd_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_pos <= wr_next;
            end
            if (i_pop && !o_empty) begin
                r_rd_pos <= rd_next;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ps2s1_top_note.sv @@
`timescale 1ns / 1ps

// Output register stage: turns the lookup-stage item and memory read data
// into the result item and holds it while the receiver stalls.
module ps2s1_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [1:0]          i_op,
    input  ps2s1_pkg::t_dec     i_dec,
    input  logic                i_dropped,
    input  logic                i_pop_ok,
    input  ps2s1_pkg::t_byte    i_ring_data,
    input  logic                i_key_pressed,
    input  logic                i_take,
    output logic                o_valid,
    output logic                o_event_valid,
    output ps2s1_pkg::t_key     o_event_key,
    output logic                o_key_pressed,
    output logic                o_event_dropped
);

    logic             r_valid;
    logic             r_event_valid, n_event_valid;
    ps2s1_pkg::t_key  r_event_key, n_event_key;
    logic             r_key_pressed, n_key_pressed;
    logic             r_event_dropped, n_event_dropped;

    always_comb begin
        n_event_valid   = 1'b0;
        n_event_key     = '0;
        n_key_pressed   = 1'b0;
        n_event_dropped = 1'b0;
        case (i_op)
            ps2s1_pkg::OP_FEED: begin
                n_event_valid   = i_dec.have;
                n_event_key     = i_dec.key;
                n_key_pressed   = i_dec.pressed;
                n_event_dropped = i_dec.have & i_dropped;
            end
            ps2s1_pkg::OP_POP: begin
                if (i_pop_ok) begin
                    n_event_valid = 1'b1;
                    n_event_key   = i_ring_data[6:0];
                    n_key_pressed = i_ring_data[7];
                end
            end
            ps2s1_pkg::OP_QUERY: begin
                n_event_valid = 1'b1;
                n_event_key   = i_dec.key;
                n_key_pressed = i_key_pressed;
            end
            default: begin
                n_event_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event_valid   <= n_event_valid;
            r_event_key     <= n_event_key;
            r_key_pressed   <= n_key_pressed;
            r_event_dropped <= n_event_dropped;
        end
    end

    assign o_valid         = r_valid;
    assign o_event_valid   = r_event_valid;
    assign o_event_key     = r_event_key;
    assign o_key_pressed   = r_key_pressed;
    assign o_event_dropped = r_event_dropped;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int unsigned RING_DEPTH   = 1024;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 420;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef struct packed {
        logic            valid;
        ps2s1_pkg::t_key key;
        logic            pressed;
        logic            dropped;
    } t_key_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ps2s1_in_if  in_ch ();
    ps2s1_out_if out_ch ();

    ps2_set1_scancode_decoder #(
        .EVENT_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decoder state as the block should hold it
    int unsigned      seq_len;
    ps2s1_pkg::t_byte seq_buf [6];
    logic             key_down [ps2s1_pkg::NUM_KEYS];
    logic [7:0]       ring_mem [RING_DEPTH];
    int unsigned      wr_ptr;
    int unsigned      rd_ptr;

    t_key_report key_reports_due [$];

    int unsigned src_idle;
    int unsigned rcv_idle;
    int unsigned err_count;
    int unsigned items_sent;
    int unsigned reports_seen;
    int unsigned drops_seen;
    int unsigned quiet_cycles;

    ps2s1_pkg::t_byte ext_codes [14] = '{8'h1C, 8'h1D, 8'h35, 8'h38, 8'h47, 8'h48, 8'h49,
                                         8'h4B, 8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53};

    function automatic ps2s1_pkg::t_key ext_key(input ps2s1_pkg::t_key code);
        case (code)
            7'h1C:   return 7'd100;
            7'h1D:   return 7'd89;
            7'h35:   return 7'd101;
            7'h38:   return 7'd88;
            7'h47:   return 7'd94;
            7'h48:   return 7'd91;
            7'h49:   return 7'd95;
            7'h4B:   return 7'd90;
            7'h4D:   return 7'd92;
            7'h4F:   return 7'd96;
            7'h50:   return 7'd93;
            7'h51:   return 7'd97;
            7'h52:   return 7'd98;
            7'h53:   return 7'd99;
            default: return 7'd0;
        endcase
    endfunction

    function automatic int unsigned ring_fill();
        return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    // advance the decoder state by one item and return the report it causes
    function automatic t_key_report decode_item(input logic [1:0] op,
                                                input ps2s1_pkg::t_byte sb,
                                                input ps2s1_pkg::t_key qk);
        t_key_report     r;
        logic            have;
        ps2s1_pkg::t_key k;
        logic            p;
        r    = '0;
        have = 1'b0;
        k    = '0;
        p    = 1'b0;
        case (op)
            ps2s1_pkg::OP_FEED: begin
                if (seq_len > 0) begin
                    if (seq_len < 6) seq_buf[seq_len] = sb;
                    seq_len++;
                    if (seq_len == 2 && seq_buf[0] == ps2s1_pkg::SC_E0) begin
                        if (seq_buf[1] != ps2s1_pkg::SC_E0_HOLD_A &&
                            seq_buf[1] != ps2s1_pkg::SC_E0_HOLD_B) begin
                            k       = ext_key(seq_buf[1][6:0]);
                            p       = (seq_buf[1] < ps2s1_pkg::SC_EXT_BREAK);
                            have    = 1'b1;
                            seq_len = 0;
                        end
                    end else if (seq_len == 4) begin
                        if (seq_buf[3] == ps2s1_pkg::SC_PRT_MAKE ||
                            seq_buf[3] == ps2s1_pkg::SC_PRT_BREAK) begin
                            k       = ps2s1_pkg::KEY_PRINT;
                            p       = (seq_buf[3] == ps2s1_pkg::SC_PRT_MAKE);
                            have    = 1'b1;
                            seq_len = 0;
                        end
                    end else if (seq_len >= 6) begin
                        seq_len = 0;
                    end
                end else if (sb == ps2s1_pkg::SC_E0 || sb == ps2s1_pkg::SC_E1) begin
                    seq_buf[0] = sb;
                    seq_len    = 1;
                end else if (sb[6:0] != 7'd0 && sb[6:0] < ps2s1_pkg::CODE_LIMIT) begin
                    k    = sb[6:0] - 7'd1;
                    p    = !sb[7];
                    have = 1'b1;
                end
                if (have) begin
                    r.valid     = 1'b1;
                    r.key       = k;
                    r.pressed   = p;
                    key_down[k] = p;
                    if ((wr_ptr + 1) % RING_DEPTH == rd_ptr) begin
                        r.dropped = 1'b1;
                    end else begin
                        ring_mem[wr_ptr] = {p, k};
                        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                    end
                end
            end
            ps2s1_pkg::OP_POP: begin
                if (rd_ptr != wr_ptr) begin
                    r.valid   = 1'b1;
                    r.key     = ring_mem[rd_ptr][6:0];
                    r.pressed = ring_mem[rd_ptr][7];
                    rd_ptr    = (rd_ptr + 1) % RING_DEPTH;
                end
            end
            ps2s1_pkg::OP_QUERY: begin
                r.valid = 1'b1;
                r.key   = qk;
                if (qk < ps2s1_pkg::NUM_KEYS) r.pressed = key_down[qk];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("tb: mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic send_item(input logic [1:0] op, input ps2s1_pkg::t_byte sb,
                             input ps2s1_pkg::t_key qk);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.scan_byte <= sb;
        in_ch.query_key <= qk;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        key_reports_due.push_back(decode_item(op, sb, qk));
        items_sent++;
    endtask

    task automatic feed_byte(input ps2s1_pkg::t_byte b);
        send_item(ps2s1_pkg::OP_FEED, b, ps2s1_pkg::t_key'($urandom_range(127)));
    endtask

    task automatic pop_event();
        send_item(ps2s1_pkg::OP_POP, ps2s1_pkg::t_byte'($urandom_range(255)),
                  ps2s1_pkg::t_key'($urandom_range(127)));
    endtask

    task automatic ask_key(input ps2s1_pkg::t_key k);
        send_item(ps2s1_pkg::OP_QUERY, ps2s1_pkg::t_byte'($urandom_range(255)), k);
    endtask

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        src_idle = snd;
        rcv_idle = rcv;
    endtask

    task automatic test_reset_state();
        ask_key(7'd0);
        ask_key(7'd127);
        pop_event();
        send_item(OP_UNUSED, 8'hFF, 7'd127);
    endtask

    task automatic test_single_byte();
        feed_byte(8'h00);
        feed_byte(8'h80);
        feed_byte(8'h59);
        feed_byte(8'hFF);
        feed_byte(8'h01);
        feed_byte(8'hD8);
    endtask

    task automatic test_extended();
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(8'h4B);
        // unmapped break code lands on key 0
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(ps2s1_pkg::SC_EXT_BREAK);
    endtask

    task automatic test_print_screen();
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(ps2s1_pkg::SC_E0_HOLD_B);
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(ps2s1_pkg::SC_PRT_MAKE);
        ask_key(ps2s1_pkg::KEY_PRINT);
    endtask

    task automatic test_pause();
        feed_byte(ps2s1_pkg::SC_E1);
        feed_byte(8'h1D);
        feed_byte(8'h45);
        feed_byte(ps2s1_pkg::SC_E1);
        feed_byte(8'h9D);
        feed_byte(8'hC5);
        pop_event();
    endtask

    task automatic send_key_sequence();
        int unsigned      pick;
        int unsigned      n;
        ps2s1_pkg::t_byte b;
        pick = $urandom_range(99);
        if (pick < 45) begin
            b = ps2s1_pkg::t_byte'($urandom_range(1, 88));
            if ($urandom_range(1)) b[7] = 1'b1;
            feed_byte(b);
        end else if (pick < 65) begin
            if ($urandom_range(1)) begin
                b = ext_codes[$urandom_range(13)];
                if ($urandom_range(1)) b[7] = 1'b1;
            end else begin
                b = ps2s1_pkg::t_byte'($urandom_range(255));
            end
            feed_byte(ps2s1_pkg::SC_E0);
            feed_byte(b);
        end else if (pick < 75) begin
            feed_byte(ps2s1_pkg::SC_E0);
            if ($urandom_range(1)) begin
                feed_byte(ps2s1_pkg::SC_E0_HOLD_B);
                feed_byte(ps2s1_pkg::SC_E0);
                feed_byte(ps2s1_pkg::SC_PRT_MAKE);
            end else begin
                feed_byte(ps2s1_pkg::SC_E0_HOLD_A);
                feed_byte(ps2s1_pkg::SC_E0);
                feed_byte(ps2s1_pkg::SC_PRT_BREAK);
            end
        end else if (pick < 82) begin
            feed_byte(ps2s1_pkg::SC_E1);
            feed_byte(8'h1D);
            feed_byte(8'h45);
            feed_byte(ps2s1_pkg::SC_E1);
            feed_byte(8'h9D);
            feed_byte(8'hC5);
        end else if (pick < 88) begin
            // broken prefix: random tail bytes
            feed_byte($urandom_range(1) ? ps2s1_pkg::SC_E0 : ps2s1_pkg::SC_E1);
            n = $urandom_range(1, 5);
            repeat (n) feed_byte(ps2s1_pkg::t_byte'($urandom_range(255)));
        end else begin
            feed_byte(ps2s1_pkg::t_byte'($urandom_range(255)));
        end
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) send_key_sequence();
            else if (pick < 85) pop_event();
            else if (pick < 97) ask_key(ps2s1_pkg::t_key'($urandom_range(127)));
            else send_item(OP_UNUSED, ps2s1_pkg::t_byte'($urandom_range(255)),
                           ps2s1_pkg::t_key'($urandom_range(127)));
        end
    endtask

    task automatic test_ring_full();
        // fill from where random traffic left the pointers, so the write side wraps
        while (ring_fill() < RING_DEPTH - 1)
            feed_byte(ps2s1_pkg::t_byte'($urandom_range(1, 88)));
        // full ring: events are lost but the key table still follows them
        feed_byte(8'h1E);
        feed_byte(8'h9E);
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(8'h48);
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(ps2s1_pkg::SC_E0_HOLD_B);
        feed_byte(ps2s1_pkg::SC_E0);
        feed_byte(ps2s1_pkg::SC_PRT_MAKE);
        ask_key(7'd29);
        ask_key(7'd91);
        ask_key(ps2s1_pkg::KEY_PRINT);
        repeat (8) pop_event();
    endtask

    // result checker and receiver-side stalls
    always @(posedge i_clk) begin : check_results
        t_key_report want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            reports_seen++;
            if (out_ch.event_dropped) drops_seen++;
            if (key_reports_due.size() == 0) begin
                report_mismatch("result with nothing pending, key", out_ch.event_key, 0);
            end else begin
                want = key_reports_due.pop_front();
                if (out_ch.event_valid !== want.valid)
                    report_mismatch("event_valid", out_ch.event_valid, want.valid);
                if (out_ch.event_key !== want.key)
                    report_mismatch("event_key", out_ch.event_key, want.key);
                if (out_ch.key_pressed !== want.pressed)
                    report_mismatch("key_pressed", out_ch.key_pressed, want.pressed);
                if (out_ch.event_dropped !== want.dropped)
                    report_mismatch("event_dropped", out_ch.event_dropped, want.dropped);
            end
        end
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: no handshake for %0d cycles", STALL_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        seq_len    = 0;
        wr_ptr     = 0;
        rd_ptr     = 0;
        err_count  = 0;
        items_sent = 0;
        foreach (key_down[i]) key_down[i] = 1'b0;
        foreach (seq_buf[i]) seq_buf[i] = '0;
        set_idling(24, 65);

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= ps2s1_pkg::OP_FEED;
        in_ch.scan_byte <= '0;
        in_ch.query_key <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_single_byte();
        test_extended();
        test_print_screen();
        test_pause();

        test_random_traffic(RANDOM_ITEMS / 3);
        set_idling(65, 24);
        test_random_traffic(RANDOM_ITEMS / 3);
        set_idling(0, 0);
        test_random_traffic(RANDOM_ITEMS / 3);
        test_ring_full();

        in_ch.valid <= 1'b0;
        while (key_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (key_reports_due.size() != 0)
            report_mismatch("results never delivered", 0, key_reports_due.size());

        $display("tb: %0d items sent, %0d results checked, %0d dropped events",
                 items_sent, reports_seen, drops_seen);
        $display("tb: one-byte, E0, print-screen, pause, broken codes, queries, pops, full ring");
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
